@@ design/pfq_pkg.sv @@
// Shared constants, types and state encoding of the priority task queue.
package pfq_pkg;

    // Default sizes of the queue.
    localparam int PFQ_QUEUE_DEPTH     = 64;
    localparam int PFQ_PRIORITY_LEVELS = 256;
    localparam int PFQ_TASK_BITS       = 16;

    // Fixed widths of the word fields on the ports.
    localparam int PFQ_ID_W   = 16;
    localparam int PFQ_PRIO_W = 8;

    // The level bitmap is searched in groups of this many levels.
    localparam int PFQ_GROUP_W = 16;

    typedef enum logic {
        CMD_PUSH = 1'b0,
        CMD_POP  = 1'b1
    } t_cmd_e;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_FIND,
        S_HEAD,
        S_POP,
        S_EMIT
    } t_state_e;

    // Requests from the sequencer to the level bitmap.
    typedef struct packed {
        logic set;
        logic clr;
        logic find;
    } t_map_cmd;

    // One result word.
    typedef struct packed {
        logic [PFQ_ID_W-1:0] popped_task;
        logic                popped_valid;
        logic                push_dropped;
        logic                queue_empty;
    } t_result;

endpackage

@@ design/priority_fifo_task_queue_unit.sv @@
// Top level of the priority task queue: sequencer, allocator and result register.
//
// The queue takes one command word on the input channel (i_valid / o_ready) and
// returns exactly one result word on the output channel (o_valid / i_ready).
// A push stores i_task_id at priority i_task_priority; a pop returns the oldest
// task of the highest priority present. Each result reports a popped task, a
// dropped push on a full queue, and whether the queue is empty afterwards.
//
// Commands are processed one at a time, and o_ready is high whenever the
// sequencer is idle. A push reads the level tail and free link, then writes
// back. A pop first picks the highest bitmap group holding a busy level, then
// resolves the level and reads its head/tail, then reads the entry, and then
// writes back. A pop on an empty queue or a push on a full one is answered
// directly from idle. These steps come from the read-modify-write through the
// entry and level memories.
//
// Reset clears the level bitmap, the free list and the counters; no memory
// clearing pass is needed. If the receiver stalls, the result waits in the
// output register, and a finished result that finds it occupied is held in the
// sequencer until the output register is free.
module priority_fifo_task_queue_unit import pfq_pkg::*; #(
    parameter int QUEUE_DEPTH     = PFQ_QUEUE_DEPTH,
    parameter int PRIORITY_LEVELS = PFQ_PRIORITY_LEVELS,
    parameter int TASK_BITS       = PFQ_TASK_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_cmd,
    input  logic [PFQ_ID_W-1:0]   i_task_id,
    input  logic signed [PFQ_PRIO_W-1:0] i_task_priority,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [PFQ_ID_W-1:0]   o_popped_task,
    output logic                  o_popped_valid,
    output logic                  o_push_dropped,
    output logic                  o_queue_empty
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int LW = $clog2(PRIORITY_LEVELS);
    localparam int SW = (TASK_BITS < PFQ_ID_W) ? TASK_BITS : PFQ_ID_W;
    localparam int PW = PFQ_PRIO_W + 2;

    // Sequencer and allocator state.
    t_state_e      r_state, n_state;
    logic [SW-1:0] r_id, n_id;
    logic [LW-1:0] r_lvl, n_lvl;
    logic [AW-1:0] r_free_head, n_free_head;
    logic [CW-1:0] r_fresh, n_fresh;
    logic [CW-1:0] r_used, n_used;
    t_result       r_res, n_res;
    t_result       r_out, n_out;
    logic          r_out_valid, n_out_valid;

    // Memory and bitmap controls.
    logic          ent_task_we, ent_link_we, ent_re;
    logic [AW-1:0] ent_task_addr, ent_link_addr, ent_link_data, ent_raddr;
    logic [SW-1:0] ent_task;
    logic [AW-1:0] ent_link;
    logic          lvl_re, lvl_head_we, lvl_tail_we;
    logic [LW-1:0] lvl_addr;
    logic [AW-1:0] lvl_head_data, lvl_tail_data, lvl_head, lvl_tail;
    t_map_cmd      map_cmd;
    logic          map_busy;
    logic [LW-1:0] map_top;

    logic          in_accept, can_load, res_set;
    logic          recycled;
    logic [AW-1:0] alloc_slot;
    logic signed [PW-1:0] prio_sum;
    logic [LW-1:0] acc_lvl;

    assign o_ready   = (r_state == S_IDLE);
    assign in_accept = i_valid && o_ready;
    assign can_load  = !r_out_valid || i_ready;

    // Entries below the fresh mark that are not in use sit on the free stack.
    assign recycled   = (r_fresh != r_used);
    assign alloc_slot = recycled ? r_free_head : r_fresh[AW-1:0];

    // Priority to level: offset by half the level count, saturated at both ends.
    assign prio_sum = PW'(i_task_priority) + PW'(PRIORITY_LEVELS / 2);
    always_comb begin
        if (prio_sum < 0) begin
            acc_lvl = '0;
        end else if (prio_sum > PW'(PRIORITY_LEVELS - 1)) begin
            acc_lvl = LW'(PRIORITY_LEVELS - 1);
        end else begin
            acc_lvl = prio_sum[LW-1:0];
        end
    end

    pfq_entry_mem #(
        .DEPTH (QUEUE_DEPTH),
        .AW    (AW),
        .SW    (SW)
    ) u_entry_mem (
        .i_clk       (i_clk),
        .i_task_we   (ent_task_we),
        .i_task_addr (ent_task_addr),
        .i_task_data (r_id),
        .i_link_we   (ent_link_we),
        .i_link_addr (ent_link_addr),
        .i_link_data (ent_link_data),
        .i_re        (ent_re),
        .i_raddr     (ent_raddr),
        .o_task      (ent_task),
        .o_link      (ent_link)
    );

    pfq_level_mem #(
        .LEVELS (PRIORITY_LEVELS),
        .LW     (LW),
        .AW     (AW)
    ) u_level_mem (
        .i_clk       (i_clk),
        .i_addr      (lvl_addr),
        .i_re        (lvl_re),
        .i_head_we   (lvl_head_we),
        .i_head_data (lvl_head_data),
        .i_tail_we   (lvl_tail_we),
        .i_tail_data (lvl_tail_data),
        .o_head      (lvl_head),
        .o_tail      (lvl_tail)
    );

    pfq_level_map #(
        .LEVELS (PRIORITY_LEVELS),
        .LW     (LW)
    ) u_level_map (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (map_cmd),
        .i_level (r_lvl),
        .o_busy  (map_busy),
        .o_top   (map_top)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_free_head <= '0;
            r_fresh     <= '0;
            r_used      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
            r_used      <= n_used;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_id  <= n_id;
        r_lvl <= n_lvl;
        r_res <= n_res;
        r_out <= n_out;
    end

    always_comb begin
        n_state       = r_state;
        n_id          = r_id;
        n_lvl         = r_lvl;
        n_free_head   = r_free_head;
        n_fresh       = r_fresh;
        n_used        = r_used;
        n_res         = r_res;
        n_out         = r_out;
        n_out_valid   = r_out_valid && !i_ready;
        res_set       = 1'b0;
        ent_task_we   = 1'b0;
        ent_task_addr = alloc_slot;
        ent_link_we   = 1'b0;
        ent_link_addr = lvl_tail;
        ent_link_data = alloc_slot;
        ent_re        = 1'b0;
        ent_raddr     = r_free_head;
        lvl_re        = 1'b0;
        lvl_addr      = r_lvl;
        lvl_head_we   = 1'b0;
        lvl_head_data = alloc_slot;
        lvl_tail_we   = 1'b0;
        lvl_tail_data = alloc_slot;
        map_cmd       = '0;

        unique case (r_state)
            S_IDLE: begin
                lvl_addr = acc_lvl;
                if (in_accept) begin
                    n_id  = i_task_id[SW-1:0];
                    n_lvl = acc_lvl;
                    if (i_cmd == CMD_PUSH) begin
                        if (r_used == CW'(QUEUE_DEPTH)) begin
                            n_res   = '{popped_task: '0, popped_valid: 1'b0,
                                        push_dropped: 1'b1, queue_empty: 1'b0};
                            res_set = 1'b1;
                        end else begin
                            // Fetch the level tail and the link of the free head.
                            lvl_re  = 1'b1;
                            ent_re  = 1'b1;
                            n_state = S_PUSH;
                        end
                    end else begin
                        if (r_used == '0) begin
                            n_res   = '{popped_task: '0, popped_valid: 1'b0,
                                        push_dropped: 1'b0, queue_empty: 1'b1};
                            res_set = 1'b1;
                        end else begin
                            map_cmd.find = 1'b1;
                            n_state      = S_FIND;
                        end
                    end
                end
            end
            S_PUSH: begin
                ent_task_we = 1'b1;
                // Append behind the current tail, or start a new list.
                if (map_busy) begin
                    ent_link_we = 1'b1;
                end else begin
                    lvl_head_we = 1'b1;
                    map_cmd.set = 1'b1;
                end
                lvl_tail_we = 1'b1;
                if (recycled) begin
                    n_free_head = ent_link;
                end else begin
                    n_fresh = r_fresh + CW'(1);
                end
                n_used  = r_used + CW'(1);
                n_res   = '{popped_task: '0, popped_valid: 1'b0,
                            push_dropped: 1'b0, queue_empty: 1'b0};
                res_set = 1'b1;
            end
            S_FIND: begin
                lvl_addr = map_top;
                lvl_re   = 1'b1;
                n_lvl    = map_top;
                n_state  = S_HEAD;
            end
            S_HEAD: begin
                ent_re    = 1'b1;
                ent_raddr = lvl_head;
                n_state   = S_POP;
            end
            S_POP: begin
                // Unlink the head entry and push it onto the free stack.
                if (lvl_head == lvl_tail) begin
                    map_cmd.clr = 1'b1;
                end else begin
                    lvl_head_we   = 1'b1;
                    lvl_head_data = ent_link;
                end
                ent_link_we   = 1'b1;
                ent_link_addr = lvl_head;
                ent_link_data = r_free_head;
                n_free_head   = lvl_head;
                n_used        = r_used - CW'(1);
                n_res         = '{popped_task: PFQ_ID_W'(ent_task), popped_valid: 1'b1,
                                  push_dropped: 1'b0, queue_empty: (r_used == CW'(1))};
                res_set       = 1'b1;
            end
            S_EMIT: begin
                if (can_load) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // A finished result goes straight to the output register when it is free.
        if (res_set) begin
            if (can_load) begin
                n_out       = n_res;
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end else begin
                n_state = S_EMIT;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_popped_task  = r_out.popped_task;
    assign o_popped_valid = r_out.popped_valid;
    assign o_push_dropped = r_out.push_dropped;
    assign o_queue_empty  = r_out.queue_empty;

endmodule

@@ design/pfq_entry_mem.sv @@
// Entry memory of the queue: task handles and the links between entries.
module pfq_entry_mem import pfq_pkg::*; #(
    parameter int DEPTH = PFQ_QUEUE_DEPTH,
    parameter int AW    = $clog2(DEPTH),
    parameter int SW    = PFQ_TASK_BITS
) (
    input  logic          i_clk,
    input  logic          i_task_we,
    input  logic [AW-1:0] i_task_addr,
    input  logic [SW-1:0] i_task_data,
    input  logic          i_link_we,
    input  logic [AW-1:0] i_link_addr,
    input  logic [AW-1:0] i_link_data,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [SW-1:0] o_task,
    output logic [AW-1:0] o_link
);

    logic [SW-1:0] r_task_mem [DEPTH];
    logic [AW-1:0] r_link_mem [DEPTH];
    logic [SW-1:0] r_task_q;
    logic [AW-1:0] r_link_q;

    always_ff @(posedge i_clk) begin
        if (i_task_we) begin
            r_task_mem[i_task_addr] <= i_task_data;
        end
        if (i_link_we) begin
            r_link_mem[i_link_addr] <= i_link_data;
        end
    end

    // Read data holds until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_task_q <= r_task_mem[i_raddr];
            r_link_q <= r_link_mem[i_raddr];
        end
    end

    assign o_task = r_task_q;
    assign o_link = r_link_q;

endmodule

@@ design/pfq_level_mem.sv @@
// Level memory: head and tail entry of the list kept for each priority level.
module pfq_level_mem import pfq_pkg::*; #(
    parameter int LEVELS = PFQ_PRIORITY_LEVELS,
    parameter int LW     = $clog2(LEVELS),
    parameter int AW     = $clog2(PFQ_QUEUE_DEPTH)
) (
    input  logic          i_clk,
    input  logic [LW-1:0] i_addr,
    input  logic          i_re,
    input  logic          i_head_we,
    input  logic [AW-1:0] i_head_data,
    input  logic          i_tail_we,
    input  logic [AW-1:0] i_tail_data,
    output logic [AW-1:0] o_head,
    output logic [AW-1:0] o_tail
);

    logic [AW-1:0] r_head_mem [LEVELS];
    logic [AW-1:0] r_tail_mem [LEVELS];
    logic [AW-1:0] r_head_q;
    logic [AW-1:0] r_tail_q;

    always_ff @(posedge i_clk) begin
        if (i_head_we) begin
            r_head_mem[i_addr] <= i_head_data;
        end
        if (i_tail_we) begin
            r_tail_mem[i_addr] <= i_tail_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_head_q <= r_head_mem[i_addr];
            r_tail_q <= r_tail_mem[i_addr];
        end
    end

    assign o_head = r_head_q;
    assign o_tail = r_tail_q;

endmodule

@@ design/pfq_level_map.sv @@
// Bitmap of non-empty priority levels with a two-step search for the highest one.
module pfq_level_map import pfq_pkg::*; #(
    parameter int LEVELS = PFQ_PRIORITY_LEVELS,
    parameter int LW     = $clog2(LEVELS)
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_map_cmd      i_cmd,
    input  logic [LW-1:0] i_level,
    output logic          o_busy,
    output logic [LW-1:0] o_top
);

    localparam int NG = (LEVELS + PFQ_GROUP_W - 1) / PFQ_GROUP_W;
    localparam int GW = (NG > 1) ? $clog2(NG) : 1;
    localparam int BW = $clog2(PFQ_GROUP_W);

    logic [LEVELS-1:0]         r_map;
    logic [NG*PFQ_GROUP_W-1:0] map_pad;
    logic [GW-1:0]             r_grp;
    logic [GW-1:0]             grp_top;
    logic [PFQ_GROUP_W-1:0]    grp_word;
    logic [BW-1:0]             bit_top;
    logic [GW+BW-1:0]          top_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map <= '0;
        end else if (i_cmd.set) begin
            r_map[i_level] <= 1'b1;
        end else if (i_cmd.clr) begin
            r_map[i_level] <= 1'b0;
        end
    end

    assign map_pad = (NG*PFQ_GROUP_W)'(r_map);
    assign o_busy  = r_map[i_level];

    // First step: the highest group that holds any busy level.
    always_comb begin
        grp_top = '0;
        for (int g = 0; g < NG; g++) begin
            if (|map_pad[g*PFQ_GROUP_W +: PFQ_GROUP_W]) begin
                grp_top = GW'(g);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.find) begin
            r_grp <= grp_top;
        end
    end

    // Second step: the highest busy level inside the chosen group.
    always_comb begin
        grp_word = '0;
        for (int g = 0; g < NG; g++) begin
            if (r_grp == GW'(g)) begin
                grp_word = map_pad[g*PFQ_GROUP_W +: PFQ_GROUP_W];
            end
        end
        bit_top = '0;
        for (int b = 0; b < PFQ_GROUP_W; b++) begin
            if (grp_word[b]) begin
                bit_top = BW'(b);
            end
        end
    end

    assign top_full = {r_grp, bit_top};
    assign o_top    = top_full[LW-1:0];

endmodule

@@ design/pfq_checker.sv @@
// Port-level checks of the priority task queue, bound to the top level.
module pfq_checker import pfq_pkg::*; (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_valid,
    input logic                  o_ready,
    input logic                  i_cmd,
    input logic [PFQ_ID_W-1:0]   i_task_id,
    input logic signed [PFQ_PRIO_W-1:0] i_task_priority,
    input logic                  o_valid,
    input logic                  i_ready,
    input logic [PFQ_ID_W-1:0]   o_popped_task,
    input logic                  o_popped_valid,
    input logic                  o_push_dropped,
    input logic                  o_queue_empty
);

    // A command word that is not taken yet stays presented and unchanged.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_ready) |=> (i_valid && $stable(i_cmd)
            && $stable(i_task_id) && $stable(i_task_priority)))
        else $error("waiting command word changed");

    // A result is either a pop answer or a push answer, never both.
    a_pop_or_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_popped_valid && o_push_dropped))
        else $error("result flags both a popped task and a dropped push");

    // A dropped push means the queue was full, so it cannot be empty.
    a_drop_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_push_dropped) |-> !o_queue_empty)
        else $error("dropped push reported with an empty queue");

    // Without a popped task the task field reads zero.
    a_no_task_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_popped_valid) |-> (o_popped_task == '0))
        else $error("task field nonzero without a popped task");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_popped_task)
            && $stable(o_popped_valid) && $stable(o_push_dropped)
            && $stable(o_queue_empty)))
        else $error("stalled result changed");

endmodule

bind priority_fifo_task_queue_unit pfq_checker u_pfq_checker (.*);

@@ verif/priority_fifo_task_queue_unit_test.sv @@
// Self-checking testbench of the priority task queue with a directed table and random phases.
`timescale 1ns / 100ps

module priority_fifo_task_queue_unit_test;
    import pfq_pkg::*;

    // The watchdog limit is far above the slowest legal run. That run has about
    // 1020 words, each waiting out sender gaps, the block's work and receiver
    // stalls.
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 8;
    localparam int RANDOM_PHASES = 10;
    localparam int PHASE_WORDS = 100;

    // One row of the directed table. Where has_want is set, the expected
    // result is typed in. Otherwise the shadow queue below supplies it.
    typedef struct {
        t_cmd_e                     cmd;
        logic [PFQ_ID_W-1:0]        task_id;
        logic signed [PFQ_PRIO_W-1:0] prio;
        bit                         has_want;
        t_result                    want;
    } t_row;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n;
    logic                          i_valid;
    logic                          o_ready;
    logic                          i_cmd;
    logic [PFQ_ID_W-1:0]           i_task_id;
    logic signed [PFQ_PRIO_W-1:0]  i_task_priority;
    logic                          o_valid;
    logic                          i_ready;
    logic [PFQ_ID_W-1:0]           o_popped_task;
    logic                          o_popped_valid;
    logic                          o_push_dropped;
    logic                          o_queue_empty;

    // The shadow of the queue keeps one arrival-ordered list of handles per
    // priority level, together with the number of waiting tasks.
    logic [PFQ_ID_W-1:0] level_fifo [PFQ_PRIORITY_LEVELS][$];
    int                  waiting_tasks = 0;

    // Results that have been predicted and have not yet come back, oldest first.
    t_result pending_results [$];
    t_row    directed_rows [$];

    int fail_count  = 0;
    int cycle_count = 0;
    // While calm is set, neither side idles.
    bit calm        = 1'b0;

    priority_fifo_task_queue_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_cmd           (i_cmd),
        .i_task_id       (i_task_id),
        .i_task_priority (i_task_priority),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_popped_task   (o_popped_task),
        .o_popped_valid  (o_popped_valid),
        .o_push_dropped  (o_push_dropped),
        .o_queue_empty   (o_queue_empty)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // A signed priority maps to a level by an offset of half the level count,
    // saturated to the valid range.
    function automatic int prio_level(input logic signed [PFQ_PRIO_W-1:0] prio);
        int lvl;
        lvl = int'(prio) + PFQ_PRIORITY_LEVELS / 2;
        if (lvl < 0) begin
            lvl = 0;
        end
        if (lvl > PFQ_PRIORITY_LEVELS - 1) begin
            lvl = PFQ_PRIORITY_LEVELS - 1;
        end
        return lvl;
    endfunction

    // This function applies one accepted command word to the shadow queue and
    // returns the result word that the block must produce for it. A push on a
    // full queue is dropped. A pop on an empty queue returns no task. The
    // fields of the other operation stay zero.
    function automatic t_result apply_command(input t_cmd_e cmd,
                                              input logic [PFQ_ID_W-1:0] task_id,
                                              input logic signed [PFQ_PRIO_W-1:0] prio);
        t_result                r;
        int                     lvl;
        logic [PFQ_ID_W-1:0]    id_mask;
        r       = '0;
        id_mask = PFQ_ID_W'((64'd1 << PFQ_TASK_BITS) - 1);
        if (cmd == CMD_PUSH) begin
            if (waiting_tasks >= PFQ_QUEUE_DEPTH) begin
                r.push_dropped = 1'b1;
            end else begin
                lvl = prio_level(prio);
                level_fifo[lvl].insert(level_fifo[lvl].size(), task_id & id_mask);
                waiting_tasks++;
            end
        end else if (waiting_tasks > 0) begin
            lvl = PFQ_PRIORITY_LEVELS - 1;
            while (lvl > 0 && level_fifo[lvl].size() == 0) begin
                lvl--;
            end
            r.popped_task  = level_fifo[lvl][0];
            level_fifo[lvl].delete(0);
            r.popped_valid = 1'b1;
            waiting_tasks--;
        end
        r.queue_empty = (waiting_tasks == 0);
        return r;
    endfunction

    function automatic bit sender_gap();
        return !calm && ($urandom_range(99) < 20);
    endfunction

    // This task presents one command word and holds it until the block takes
    // it. The task is entered at a falling edge and returns at a falling edge.
    // Inputs change only at falling edges, and i_valid gets one assignment per
    // edge, so back-to-back words keep i_valid high.
    task automatic send_word(input t_cmd_e cmd, input logic [PFQ_ID_W-1:0] task_id,
                             input logic signed [PFQ_PRIO_W-1:0] prio,
                             input bit has_want, input t_result want);
        t_result predicted;
        while (sender_gap()) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_cmd           <= cmd;
        i_task_id       <= task_id;
        i_task_priority <= prio;
        do begin
            @(posedge i_clk);
        end while (!o_ready);
        // The word was accepted at this edge. The shadow queue is updated even
        // when the expected result is typed in, so that later rows stay in step.
        predicted = apply_command(cmd, task_id, prio);
        pending_results.insert(pending_results.size(), has_want ? want : predicted);
        @(negedge i_clk);
    endtask

    task automatic add_row(input t_cmd_e cmd, input logic [PFQ_ID_W-1:0] task_id,
                           input logic signed [PFQ_PRIO_W-1:0] prio,
                           input bit has_want, input t_result want);
        t_row row;
        row.cmd      = cmd;
        row.task_id  = task_id;
        row.prio     = prio;
        row.has_want = has_want;
        row.want     = want;
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // The receiver stalls at random, in step with the sender's calm stretch.
    always @(negedge i_clk) begin
        i_ready <= calm ? 1'b1 : ($urandom_range(99) >= 20);
    end

    // Each result word taken at a rising edge is compared with the oldest
    // expectation.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_results.size() == 0) begin
                $error("result word with no expectation waiting: task %h", o_popped_task);
                fail_count++;
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (o_popped_task !== want.popped_task) begin
                    $error("popped_task: expected %h, got %h", want.popped_task,
                           o_popped_task);
                    fail_count++;
                end
                if (o_popped_valid !== want.popped_valid) begin
                    $error("popped_valid: expected %b, got %b", want.popped_valid,
                           o_popped_valid);
                    fail_count++;
                end
                if (o_push_dropped !== want.push_dropped) begin
                    $error("push_dropped: expected %b, got %b", want.push_dropped,
                           o_push_dropped);
                    fail_count++;
                end
                if (o_queue_empty !== want.queue_empty) begin
                    $error("queue_empty: expected %b, got %b", want.queue_empty,
                           o_queue_empty);
                    fail_count++;
                end
            end
        end
    end

    // The watchdog ends a run that hangs.
    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("[priority_fifo_task_queue_unit] ERROR");
        $finish;
    end

    initial begin
        t_row                         row;
        int                           push_pct;
        int                           pick;
        t_cmd_e                       cmd;
        logic signed [PFQ_PRIO_W-1:0] prio;

        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_cmd           = CMD_PUSH;
        i_task_id       = '0;
        i_task_priority = '0;
        i_ready         = 1'b0;

        // Directed rows. The first rows check the empty queue after reset.
        // Handles and priorities at their extremes follow, then more tasks on those
        // extreme levels to test FIFO order within a level. The queue is then drained
        // down to a pop on an empty queue.
        add_row(CMD_POP,  16'h0000,    8'sd0, 1'b1, {16'h0000, 1'b0, 1'b0, 1'b1});
        add_row(CMD_PUSH, 16'hFFFF,  8'sd127, 1'b1, {16'h0000, 1'b0, 1'b0, 1'b0});
        add_row(CMD_PUSH, 16'h0000, -8'sd128, 1'b1, {16'h0000, 1'b0, 1'b0, 1'b0});
        add_row(CMD_PUSH, 16'h1234,    8'sd0, 1'b0, '0);
        add_row(CMD_PUSH, 16'h5555,  8'sd127, 1'b0, '0);
        add_row(CMD_PUSH, 16'hAAAA, -8'sd128, 1'b0, '0);
        add_row(CMD_PUSH, 16'h00FF,   -8'sd1, 1'b0, '0);
        add_row(CMD_PUSH, 16'h0F0F,    8'sd1, 1'b0, '0);
        add_row(CMD_POP,  16'h0000,    8'sd0, 1'b0, '0);
        add_row(CMD_POP,  16'h0000,    8'sd0, 1'b0, '0);
        add_row(CMD_POP,  16'h0000,    8'sd0, 1'b0, '0);
        add_row(CMD_PUSH, 16'h8001,  8'sd127, 1'b0, '0);
        add_row(CMD_POP,  16'h0000,    8'sd0, 1'b0, '0);
        add_row(CMD_POP,  16'h0000,    8'sd0, 1'b0, '0);
        add_row(CMD_POP,  16'h0000,    8'sd0, 1'b0, '0);
        add_row(CMD_POP,  16'h0000,    8'sd0, 1'b0, '0);
        add_row(CMD_POP,  16'h0000,    8'sd0, 1'b0, '0);
        add_row(CMD_POP,  16'hFFFF, -8'sd128, 1'b1, {16'h0000, 1'b0, 1'b0, 1'b1});
        add_row(CMD_PUSH, 16'h7FFE, -8'sd128, 1'b1, {16'h0000, 1'b0, 1'b0, 1'b0});
        add_row(CMD_POP,  16'h0000,    8'sd0, 1'b0, '0);

        // Synchronous reset is held and then released at a falling edge.
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            send_word(row.cmd, row.task_id, row.prio, row.has_want, row.want);
        end

        // The random phases cycle through fill, drain and mixed traffic. A fill
        // phase runs the queue into the full state, where pushes are dropped. A
        // drain phase empties it and then pops an empty queue. Two in five priorities
        // fall on a few levels, so many tasks share a level and FIFO order is
        // exercised. The rest hit the extremes or spread over the full range.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            case (ph % 3)
                0:       push_pct = 85;
                1:       push_pct = 15;
                default: push_pct = 50;
            endcase
            calm = (ph == 5);
            for (int k = 0; k < PHASE_WORDS; k++) begin
                cmd  = ($urandom_range(99) < push_pct) ? CMD_PUSH : CMD_POP;
                pick = $urandom_range(9);
                if (pick < 4) begin
                    prio = PFQ_PRIO_W'($urandom_range(3)) - 8'sd1;
                end else if (pick < 6) begin
                    prio = $urandom_range(1) ? 8'sd127 : -8'sd128;
                end else begin
                    prio = PFQ_PRIO_W'($urandom);
                end
                send_word(cmd, PFQ_ID_W'($urandom), prio, 1'b0, '0);
            end
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        // All results are drained, and the bench then keeps clocking so that a
        // late extra word can show up.
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d expected result words never arrived", pending_results.size());
            fail_count++;
        end

        if (fail_count == 0) begin
            $display("[priority_fifo_task_queue_unit] OK");
        end else begin
            $display("[priority_fifo_task_queue_unit] ERROR");
        end
        $finish;
    end

endmodule
